// ===== rtl/positional_list_store_defines.svh =====
// assertion macros for the positional list store
`ifndef POSITIONAL_LIST_STORE_DEFINES_SVH
`define POSITIONAL_LIST_STORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PLS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define PLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/pls_pkg.sv =====
// types and codes shared by the positional list store modules
package pls_pkg;

  typedef enum logic [1:0] {
    ACT_APPEND  = 2'd0,
    ACT_READ    = 2'd1,
    ACT_REMOVE  = 2'd2,
    ACT_REPLACE = 2'd3
  } pls_act_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2
  } pls_status_t;

  localparam int unsigned PosW = 7;
  localparam int unsigned CntW = 7;
  localparam int unsigned ValW = 32;

  typedef struct packed {
    pls_act_t              action;
    logic [PosW-1:0]       position;
    logic signed [ValW-1:0] value;
  } pls_in_t;

  typedef struct packed {
    logic signed [ValW-1:0] read_value;
    pls_status_t            status;
    logic [CntW-1:0]        count;
  } pls_out_t;

  // per-item command broadcast to every cell
  typedef struct packed {
    logic            app;
    logic            rd;
    logic            rm;
    logic            rep;
    logic [ValW-1:0] value;
  } pls_cmd_t;

endpackage

// ===== rtl/pls_cell.sv =====
// one list entry: loads on append or replace, takes its neighbor on remove
module pls_cell
  import pls_pkg::*;
#(
  parameter int unsigned IDX = 0,
  parameter int unsigned IW  = 7
) (
  input  logic            clk,
  input  pls_cmd_t        cmd,
  input  logic [IW-1:0]   pos_idx,
  input  logic [IW-1:0]   count,
  input  logic [ValW-1:0] shift_in,
  output logic [ValW-1:0] data_out,
  output logic [ValW-1:0] rd_out
);

  localparam logic [IW-1:0] MyIdx = IW'(IDX);

  logic [ValW-1:0] data_r;
  logic [ValW-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (cmd.app && (count == MyIdx)) begin
      data_nxt = cmd.value;
    end else if (cmd.rep && (pos_idx == MyIdx)) begin
      data_nxt = cmd.value;
    end else if (cmd.rm && (MyIdx >= pos_idx)) begin
      data_nxt = shift_in;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_out = data_r;
  assign rd_out   = (cmd.rd && (pos_idx == MyIdx)) ? data_r : '0;

endmodule

// ===== rtl/positional_list_store.sv =====
// top level of the positional list store: cell row, count and result register
//
// usage
//   in channel (in_valid/in_ready/in_data) takes one item: append, read,
//   remove or replace at a 1-based position
//   out channel (out_valid/out_ready/out_data) returns one item per input
//   item with the read value, a status code and the entry count after it
//   entries live in a row of DEPTH cells; a remove shifts every cell past
//   the position one step toward the head in the same cycle
//   the result is registered and presented in the cycle after the item is accepted
//   throughput: one item per cycle while out_ready is high, set by the single result register
//   in_ready is high while the result register is empty or being drained,
//   so a stalled receiver holds the result and blocks the next item
//   reset (rst_n low at a clock edge) empties the list and the result
//   register; entry contents are not cleared, and no clearing pass is needed
//   a bad position leaves the list unchanged; appending to a full list
//   reports full and leaves the list unchanged
`include "positional_list_store_defines.svh"

module positional_list_store
  import pls_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  pls_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output pls_out_t out_data
);

  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > PosW) ? CW : PosW;
  localparam int unsigned OW   = (CW > CntW) ? CW : CntW;

  logic [CW-1:0]   count_r;
  logic [CW-1:0]   count_nxt;
  logic            out_valid_r;
  pls_out_t        out_data_r;
  pls_out_t        res;

  logic            in_fire;
  logic            full;
  logic            pos_ok;
  logic [CMPW-1:0] pos_x;
  logic [CMPW-1:0] cnt_x;
  logic [CW-1:0]   pos_idx;
  logic [OW-1:0]   cnt_out_x;
  pls_cmd_t        cmd;

  logic [ValW-1:0] cell_q  [DEPTH];
  logic [ValW-1:0] cell_rd [DEPTH];
  logic [ValW-1:0] rd_or;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign full    = (count_r == CW'(DEPTH));
  assign pos_x   = CMPW'(in_data.position);
  assign cnt_x   = CMPW'(count_r);
  assign pos_ok  = (pos_x != '0) && (pos_x <= cnt_x);
  assign pos_idx = CW'(pos_x - CMPW'(1));

  always_comb begin
    cmd       = '0;
    cmd.value = in_data.value;
    if (in_fire) begin
      case (in_data.action)
        ACT_APPEND:  cmd.app = !full;
        ACT_READ:    cmd.rd  = pos_ok;
        ACT_REMOVE:  cmd.rm  = pos_ok;
        ACT_REPLACE: cmd.rep = pos_ok;
        default:     cmd     = '0;
      endcase
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [ValW-1:0] nb;
    if (g == DEPTH - 1) begin : g_last
      assign nb = cell_q[g];
    end else begin : g_mid
      assign nb = cell_q[g+1];
    end
    pls_cell #(
      .IDX (g),
      .IW  (CW)
    ) u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .pos_idx  (pos_idx),
      .count    (count_r),
      .shift_in (nb),
      .data_out (cell_q[g]),
      .rd_out   (cell_rd[g])
    );
  end

  always_comb begin
    rd_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_or = rd_or | cell_rd[i];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.app) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.rm) begin
      count_nxt = count_r - CW'(1);
    end
  end

  assign cnt_out_x = OW'(count_nxt);

  always_comb begin
    res            = '0;
    res.read_value = rd_or;
    res.count      = cnt_out_x[CntW-1:0];
    case (in_data.action)
      ACT_APPEND: res.status = full ? ST_FULL : ST_OK;
      default:    res.status = pos_ok ? ST_OK : ST_BAD_POS;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `PLS_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(DEPTH), "entry count above depth")
  `PLS_ASSERT_NEXT(a_append_grows, cmd.app, count_r == CW'($past(count_r) + CW'(1)), "append did not grow count")
  `PLS_ASSERT_NEXT(a_bad_pos_zero, in_fire && (in_data.action != ACT_APPEND) && !pos_ok, (out_data_r.read_value == '0) && (out_data_r.status == ST_BAD_POS), "bad position result wrong")
  `PLS_ASSERT_NOW(a_full_count, out_valid_r && (out_data_r.status == ST_FULL), count_r == CW'(DEPTH), "full reported below depth")

endmodule
